// ----- hw/rtl/shc_pkg.sv -----
// Shared constants and types for the 3x3 sharpening filter.
package shc_pkg;

  localparam int MaxWidth = 2048;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = 12;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCenter = 2'd2;

  localparam logic [11:0] ResetWidth = 12'd2048;
  localparam logic [12:0] ResetHeight = 13'd4096;
  localparam logic [7:0] ResetCenter = 8'd13;
  localparam logic [7:0] KernelBias = 8'd12;
  localparam logic [7:0] PixMax = 8'd255;

  // Weighted sum: |sum| < 255*255 + 12*255, 18 bits plus sign.
  localparam int SumW = 19;
  localparam int DivW = 18;

  // Control carried from the front end to the divider.
  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            last;
    logic            err;
  } shc_tag_t;

endpackage

// ----- hw/rtl/shc_divider.sv -----
// Serial restoring divider with clamp for the normalized filter output.
module shc_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [shc_pkg::SumW-1:0] dividend,
  input  logic signed [8:0]             divisor,
  input  shc_pkg::shc_tag_t             tag_in,
  output logic                          busy,
  output logic                          done,
  output logic [7:0]                    quot_px,
  output shc_pkg::shc_tag_t             tag_out
);

  localparam int N = shc_pkg::DivW;
  localparam int CntW = $clog2(N + 1);

  logic [N-1:0]      num_r, num_nxt;
  logic [8:0]        den_r;
  logic [8:0]        rem_r, rem_nxt;
  logic              neg_r;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r, done_r;
  shc_pkg::shc_tag_t tag_r;
  logic [9:0]        trial;
  logic [N-1:0]      num_abs;
  logic [8:0]        den_abs;

  assign num_abs = dividend[shc_pkg::SumW-1] ? N'(-dividend) : N'(dividend);
  assign den_abs = divisor[8] ? 9'(-divisor) : 9'(divisor);

  // One quotient bit per cycle; the quotient shifts into num_r.
  always_comb begin
    trial = {rem_r, num_r[N-1]} - {1'b0, den_r};
    if (!trial[9]) begin
      rem_nxt = trial[8:0];
      num_nxt = {num_r[N-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[7:0], num_r[N-1]};
      num_nxt = {num_r[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(N);
        num_r  <= num_abs;
        den_r  <= tag_in.err ? 9'd1 : den_abs;
        rem_r  <= '0;
        neg_r  <= dividend[shc_pkg::SumW-1] ^ divisor[8];
        tag_r  <= tag_in;
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Truncated quotient clamped to the pixel range; zero on a divide error.
  always_comb begin
    if (tag_r.err || neg_r || num_r == '0) quot_px = '0;
    else if (num_r > N'(shc_pkg::PixMax)) quot_px = shc_pkg::PixMax;
    else quot_px = num_r[7:0];
  end

  assign busy = busy_r;
  assign done = done_r;
  assign tag_out = tag_r;

endmodule

// ----- hw/rtl/sharpen_3x3_convolution_unit.sv -----
// Top level of the 3x3 sharpening filter: line memories, window and output stage.
//
//   Channel | Ports                                      | Direction
//   in      | in_valid, in_ready, in_pixel               | input items
//   out     | out_valid, out_ready, out_pixel, out_x,    | result items
//           | out_y, out_div_error, out_last             |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register writes
//
// A border pixel takes a memory read, then write-back and window shift.
// An interior pixel then goes through ST_SUM and ST_MUL for the sum and through the serial
// divider; the bit-serial divider sets the time per pixel.
// Reset is synchronous and clears control state; line memories are not cleared.
// A result waits in the output register; the next item is accepted meanwhile and
// stalls only when its own result would need that register while still full.
module sharpen_3x3_convolution_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel,
  output logic [10:0] out_x,
  output logic [11:0] out_y,
  output logic        out_div_error,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int ColW = shc_pkg::ColW;
  localparam int RowW = shc_pkg::RowW;
  localparam int SumW = shc_pkg::SumW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SUM, ST_MUL, ST_DIV, ST_WAIT
  } state_t;

  state_t state_r;

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [7:0]  center_r;
  logic [ColW-1:0] col_r;
  logic [RowW-1:0] row_r;
  logic [7:0]  px_r;
  logic [7:0]  win_r [9];

  logic [7:0] line_two [shc_pkg::MaxWidth];
  logic [7:0] line_one [shc_pkg::MaxWidth];
  logic [7:0] top_rd_r, mid_rd_r;

  logic [12:0] w_used;
  logic [13:0] h_used;
  logic        col_end, row_end, interior;

  logic signed [SumW-1:0] neigh_r, prod_r, sum_val;
  logic signed [8:0]      ksum;
  shc_pkg::shc_tag_t      tag_r;

  logic        div_start, div_busy, div_done;
  logic [7:0]  div_px;
  shc_pkg::shc_tag_t div_tag;

  logic        ov_r;
  logic [7:0]  opx_r;
  shc_pkg::shc_tag_t otag_r;

  // Clamped geometry.
  always_comb begin
    if (width_r < 12'd3) w_used = 13'd3;
    else if ({1'b0, width_r} > 13'(shc_pkg::MaxWidth)) w_used = 13'(shc_pkg::MaxWidth);
    else w_used = {1'b0, width_r};
    if (height_r < 13'd3) h_used = 14'd3;
    else if ({1'b0, height_r} > 14'd4096) h_used = 14'd4096;
    else h_used = {1'b0, height_r};
    col_end  = 13'({1'b0, col_r} + 1'b1) >= w_used;
    row_end  = 14'({1'b0, row_r} + 1'b1) >= h_used;
    interior = (col_r >= ColW'(2)) && (row_r >= RowW'(2));
  end

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE) && !div_busy && !div_done && !ov_r;
  assign ksum      = $signed({1'b0, center_r}) - $signed({1'b0, shc_pkg::KernelBias});
  assign sum_val   = prod_r - neigh_r;
  assign div_start = (state_r == ST_MUL);

  // Line memories: read at accept, written back in the cycle after, in ST_READ.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      top_rd_r <= line_two[col_r];
      mid_rd_r <= line_one[col_r];
    end
    if (state_r == ST_READ) begin
      line_two[col_r] <= mid_rd_r;
      line_one[col_r] <= px_r;
    end
  end

  // Sequencer, window, counters and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      width_r  <= shc_pkg::ResetWidth;
      height_r <= shc_pkg::ResetHeight;
      center_r <= shc_pkg::ResetCenter;
      col_r    <= '0;
      row_r    <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          shc_pkg::CfgWidth: begin
            width_r <= cfg_data[11:0];
            col_r <= '0;
            row_r <= '0;
          end
          shc_pkg::CfgHeight: begin
            height_r <= cfg_data;
            col_r <= '0;
            row_r <= '0;
          end
          shc_pkg::CfgCenter: center_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            px_r    <= in_pixel;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k*3]   <= win_r[k*3+1];
            win_r[k*3+1] <= win_r[k*3+2];
          end
          win_r[2] <= top_rd_r;
          win_r[5] <= mid_rd_r;
          win_r[8] <= px_r;
          tag_r.x    <= ColW'(col_r - 1'b1);
          tag_r.y    <= RowW'(row_r - 1'b1);
          tag_r.last <= col_end && row_end;
          tag_r.err  <= (center_r == shc_pkg::KernelBias);
          state_r <= interior ? ST_SUM : ST_IDLE;
          if (col_end) begin
            col_r <= '0;
            row_r <= row_end ? '0 : RowW'(row_r + 1'b1);
          end else begin
            col_r <= ColW'(col_r + 1'b1);
          end
        end
        ST_SUM: begin
          neigh_r <= SumW'(win_r[0]) + SumW'(win_r[2]) + SumW'(win_r[6])
                   + SumW'(win_r[8])
                   + ((SumW'(win_r[1]) + SumW'(win_r[3]) + SumW'(win_r[5])
                   + SumW'(win_r[7])) << 1);
          prod_r  <= SumW'(center_r) * SumW'(win_r[4]);
          state_r <= ST_MUL;
        end
        ST_MUL: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) state_r <= (ov_r && !out_ready) ? ST_WAIT : ST_IDLE;
        end
        ST_WAIT: if (!ov_r || out_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  shc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_val),
    .divisor  (ksum),
    .tag_in   (tag_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot_px  (div_px),
    .tag_out  (div_tag)
  );

  // Output register; a finished result waits in the divider until it is free.
  logic load_out;
  assign load_out = (state_r == ST_DIV && div_done && (!ov_r || out_ready))
                 || (state_r == ST_WAIT && (!ov_r || out_ready));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (load_out) begin
      opx_r  <= div_px;
      otag_r <= div_tag;
    end
  end

  assign out_valid     = ov_r;
  assign out_pixel     = opx_r;
  assign out_x         = otag_r.x;
  assign out_y         = otag_r.y;
  assign out_div_error = otag_r.err;
  assign out_last      = otag_r.last;

endmodule

// ----- tb/sharpen_3x3_convolution_unit_tb.sv -----
// Self-checking testbench for the 3x3 sharpening filter: directed frames, random frames, stalls.
module sharpen_3x3_convolution_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [shc_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int SettleCycles = 40;
  localparam int WideWidth = 256;

  typedef struct packed {
    logic [7:0]  pix;
    logic [10:0] x;
    logic [11:0] y;
    logic        err;
    logic        last;
  } sharpened_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel;
  logic [10:0] out_x;
  logic [11:0] out_y;
  logic        out_div_error;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  sharpen_3x3_convolution_unit dut (.*);

  // Predictor state.
  logic [7:0]  row_two_up [shc_pkg::MaxWidth];
  logic [7:0]  row_one_up [shc_pkg::MaxWidth];
  logic [7:0]  win [9];
  int          col_pos, row_pos;
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  weight_reg;

  sharpened_t  pending_q[$];
  int          fails = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          hold_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Computes the filtered result, if any, that one accepted pixel causes.
  function automatic bit sharpen_pixel(input logic [7:0] px, output sharpened_t res);
    int w, h, c, r, corners, edges, acc, ksum, q;
    logic [7:0] top, mid;
    w = (width_reg < 3) ? 3 : (width_reg > shc_pkg::MaxWidth) ? shc_pkg::MaxWidth : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
    c = (col_pos >= shc_pkg::MaxWidth) ? shc_pkg::MaxWidth - 1 : col_pos;
    r = row_pos;
    top = row_two_up[c];
    mid = row_one_up[c];
    row_two_up[c] = mid;
    row_one_up[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    res = '0;
    sharpen_pixel = 1'b0;
    if (c >= 2 && r >= 2) begin
      corners = win[0] + win[2] + win[6] + win[8];
      edges = win[1] + win[3] + win[5] + win[7];
      acc = int'(weight_reg) * int'(win[4]) - corners - 2 * edges;
      ksum = int'(weight_reg) - 12;
      if (ksum == 0) begin
        res.err = 1'b1;
      end else begin
        q = acc / ksum;
        q = (q > 255) ? 255 : (q < 0) ? 0 : q;
        res.pix = q[7:0];
      end
      res.x = 11'(c - 1);
      res.y = 12'(r - 1);
      res.last = (c + 1 >= w && r + 1 >= h);
      sharpen_pixel = 1'b1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Receiver: random or held-off ready, and the result check.
  always @(posedge clk) begin
    sharpened_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pixel, out_x, out_y, out_div_error, out_last};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
          fails++;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Sends one pixel item and records its expected result.
  task automatic send_pixel(input logic [7:0] px);
    sharpened_t res;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    if (sharpen_pixel(px, res)) pending_q.push_back(res);
  endtask

  // Stops the input and waits until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      shc_pkg::CfgWidth: begin
        width_reg = data[11:0];
        col_pos = 0;
        row_pos = 0;
      end
      shc_pkg::CfgHeight: begin
        height_reg = data;
        col_pos = 0;
        row_pos = 0;
      end
      shc_pkg::CfgCenter: weight_reg = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int w, input int h, input int cw);
    write_reg(shc_pkg::CfgWidth, 13'(w));
    write_reg(shc_pkg::CfgHeight, 13'(h));
    write_reg(shc_pkg::CfgCenter, 13'(cw));
  endtask

  // Extremes of the pixel range, zero kernel sum, clamped geometry, restart.
  task automatic test_directed();
    set_geometry(3, 3, shc_pkg::ResetCenter);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? shc_pkg::PixMax : 8'd0);
    write_reg(shc_pkg::CfgCenter, 13'(shc_pkg::KernelBias));
    for (int i = 0; i < 9; i++) send_pixel(8'($urandom));
    // Width and height below the minimum act as 3; bit 12 of width is dropped.
    write_reg(shc_pkg::CfgWidth, 13'h1000);
    write_reg(shc_pkg::CfgHeight, 13'd0);
    write_reg(shc_pkg::CfgCenter, 13'd0);
    for (int i = 0; i < 5; i++) send_pixel(shc_pkg::PixMax);
    // A geometry write in mid-frame restarts the frame.
    write_reg(shc_pkg::CfgWidth, 13'd3);
    write_reg(CfgSpare, 13'h1FFF);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : shc_pkg::PixMax);
    write_reg(shc_pkg::CfgCenter, 13'd255);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? shc_pkg::PixMax : 8'd0);
  endtask

  // Wide lines, and a width above the maximum that acts as the maximum.
  task automatic test_wide_frame();
    set_geometry(WideWidth, 3, $urandom_range(255));
    for (int i = 0; i < 3 * WideWidth; i++) send_pixel(8'($urandom));
    write_reg(shc_pkg::CfgHeight, 13'h1FFF);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
    write_reg(shc_pkg::CfgWidth, 13'd4095);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
  endtask

  // Random geometries and weights, mostly whole frames, some cut short.
  task automatic test_random_frames(input int items);
    int sent, w, h, cw, n, mode;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(99);
      w = (mode < 70) ? $urandom_range(3, 12) : (mode < 90) ? $urandom_range(13, 64) : 3;
      h = ($urandom_range(9) == 0) ? $urandom_range(4096, 8191) : $urandom_range(3, 6);
      case ($urandom_range(7))
        0: cw = 0;
        1: cw = 12;
        2: cw = 13;
        3: cw = 255;
        default: cw = $urandom_range(255);
      endcase
      if ($urandom_range(4) == 0) begin
        write_reg(shc_pkg::CfgCenter, 13'(cw));
      end else begin
        set_geometry(w, h, cw);
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(1, 30) : w * (h > 6 ? 6 : h);
      mode = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        send_pixel((mode == 0) ? (($urandom_range(1) == 1) ? shc_pkg::PixMax : 8'd0)
                               : 8'($urandom));
      end
      sent += n;
    end
  endtask

  // Long receiver hold-off while items keep coming, then a full pause.
  task automatic test_backpressure();
    int saved;
    set_geometry(5, 40, 20);
    saved = snd_idle;
    snd_idle = 0;
    hold_cycles = 300;
    for (int i = 0; i < 120; i++) send_pixel(8'($urandom));
    drain();
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
    snd_idle = saved;
  endtask

  initial begin
    for (int i = 0; i < shc_pkg::MaxWidth; i++) begin
      row_two_up[i] = '0;
      row_one_up[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = shc_pkg::ResetWidth;
    height_reg = shc_pkg::ResetHeight;
    weight_reg = shc_pkg::ResetCenter;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 11;
    rcv_idle = 75;
    test_directed();
    test_wide_frame();
    test_random_frames(250);
    test_backpressure();
    snd_idle = 75;
    rcv_idle = 11;
    test_random_frames(250);
    snd_idle = 0;
    rcv_idle = 0;
    test_random_frames(250);
    drain();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/shc_pkg.sv
hw/rtl/shc_divider.sv
hw/rtl/sharpen_3x3_convolution_unit.sv
tb/sharpen_3x3_convolution_unit_tb.sv
